>>> src/adm_pkg.sv
package adm_pkg;

	// Tab count and derived tab selector width
	localparam int NUM_TABS = 4;
	localparam int TAB_W    = (NUM_TABS > 1) ? $clog2(NUM_TABS) : 1;

	// Timing constants in milliseconds
	localparam logic [31:0] DIM_AFTER_MS = 32'd30000;
	localparam logic [31:0] OFF_AFTER_MS = 32'd150000;
	localparam logic [31:0] REDRAW_MS    = 32'd250;

	// Blink phase: now / 500 == (now >> 2) / 125; reciprocal of 125 scaled by 2^37
	localparam int          BLINK_SHIFT = 37;
	localparam logic [30:0] BLINK_RECIP = 31'd1099511628;

	// Register reset values
	localparam logic [14:0] CO_LEVEL_ONE_RST   = 15'd100;
	localparam logic [14:0] CO_LEVEL_TWO_RST   = 15'd300;
	localparam logic [14:0] CO_LEVEL_THREE_RST = 15'd700;
	localparam logic [7:0]  CO_MARGIN_RST      = 8'd5;
	localparam logic [15:0] BAT_LOW_RST        = 16'd6500;
	localparam logic [15:0] BAT_RELEASE_RST    = 16'd6800;
	localparam logic [15:0] BAT_SENSE_MIN_RST  = 16'd4500;
	localparam logic [15:0] LONG_PRESS_RST     = 16'd400;

	typedef enum logic [2:0] {
		REG_CO_LEVEL_ONE   = 3'd0,
		REG_CO_LEVEL_TWO   = 3'd1,
		REG_CO_LEVEL_THREE = 3'd2,
		REG_CO_MARGIN      = 3'd3,
		REG_BAT_LOW        = 3'd4,
		REG_BAT_RELEASE    = 3'd5,
		REG_BAT_SENSE_MIN  = 3'd6,
		REG_LONG_PRESS     = 3'd7
	} reg_index_t;

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_PRESS   = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_SAMPLE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		PWR_FULL = 2'd0,
		PWR_DIM  = 2'd1,
		PWR_OFF  = 2'd2
	} power_t;

	typedef enum logic [2:0] {
		SCR_NONE     = 3'd0,
		SCR_CO_ALARM = 3'd1,
		SCR_BATTERY  = 3'd2,
		SCR_GRAPH    = 3'd3,
		SCR_VALUE    = 3'd4
	} screen_t;

	typedef struct packed {
		logic [14:0] co_level_one;
		logic [14:0] co_level_two;
		logic [14:0] co_level_three;
		logic [7:0]  co_release_margin;
		logic [15:0] battery_low_mv;
		logic [15:0] battery_release_mv;
		logic [15:0] battery_sense_min_mv;
		logic [15:0] graph_hold_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [31:0]        now_ms;
		logic signed [15:0] co_reading;
		logic               co_present;
		logic [15:0]        battery_mv;
	} in_word_t;

	typedef struct packed {
		logic [1:0] power_mode;
		logic [1:0] alarm_level;
		logic       invert_on;
		logic [2:0] screen;
		logic [1:0] tab_index;
		logic       battery_reminder;
	} out_word_t;

endpackage

>>> src/adm_phase.sv
module adm_phase (
	input  logic [31:0] now_ms,
	output logic        phase
);
	import adm_pkg::*;

	logic [60:0] prod;

	// Quotient by 500 through reciprocal multiply; its low bit is the blink phase
	assign prod  = 61'(now_ms[31:2]) * 61'(BLINK_RECIP);
	assign phase = prod[BLINK_SHIFT];

endmodule

>>> src/adm_core.sv
module adm_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  adm_pkg::in_word_t item,
	input  logic              phase,
	input  adm_pkg::cfg_t     cfg,
	output adm_pkg::out_word_t result
);
	import adm_pkg::*;

	// State registers
	logic [TAB_W-1:0]   tab_sel_q;
	logic [1:0]         alarm_lvl_q;
	logic               bat_latched_q;
	logic               bat_acked_q;
	power_t             power_q;
	logic [31:0]        last_act_q;
	logic [31:0]        last_redraw_q;
	logic               blink_q;
	logic               held_q;
	logic               rotate_q;
	logic               graph_q;
	logic [31:0]        press_time_q;
	logic signed [15:0] co_value_q;
	logic               co_valid_q;
	logic [15:0]        battery_q;
	logic               redraw_due_q;

	// Next state
	logic [TAB_W-1:0]   tab_sel_d;
	logic [1:0]         alarm_lvl_d;
	logic               bat_latched_d;
	logic               bat_acked_d;
	power_t             power_d;
	logic [31:0]        last_act_d;
	logic [31:0]        last_redraw_d;
	logic               blink_d;
	logic               held_d;
	logic               rotate_d;
	logic               graph_d;
	logic [31:0]        press_time_d;
	logic signed [15:0] co_value_d;
	logic               co_valid_d;
	logic [15:0]        battery_d;
	logic               redraw_due_d;
	screen_t            screen_d;

	logic [14:0]        th [3];
	logic [TAB_W+1:0]   tab_wide;

	assign th[0] = cfg.co_level_one;
	assign th[1] = cfg.co_level_two;
	assign th[2] = cfg.co_level_three;

	// Evaluate one item against the current state
	always_comb begin
		logic signed [16:0] co_ext;
		logic signed [16:0] th_ext;
		logic signed [16:0] rel_ext;
		logic [1:0]         lvl;
		logic               bat_low;
		logic               takeover;
		logic [31:0]        idle;
		logic [15:0]        bat_limit;

		tab_sel_d     = tab_sel_q;
		alarm_lvl_d   = alarm_lvl_q;
		bat_latched_d = bat_latched_q;
		bat_acked_d   = bat_acked_q;
		power_d       = power_q;
		last_act_d    = last_act_q;
		last_redraw_d = last_redraw_q;
		blink_d       = blink_q;
		held_d        = held_q;
		rotate_d      = rotate_q;
		graph_d       = graph_q;
		press_time_d  = press_time_q;
		co_value_d    = co_value_q;
		co_valid_d    = co_valid_q;
		battery_d     = battery_q;
		redraw_due_d  = redraw_due_q;
		screen_d      = SCR_NONE;
		co_ext        = {co_value_q[15], co_value_q};
		th_ext        = '0;
		rel_ext       = '0;
		lvl           = 2'd0;
		bat_low       = 1'b0;
		takeover      = 1'b0;
		idle          = '0;
		bat_limit     = '0;

		case (cmd_t'(item.cmd))
			CMD_TICK: begin
				// Long hold turns on the graph
				if (held_q) begin
					last_act_d = item.now_ms;
					if (rotate_q && !graph_q &&
					    (item.now_ms - press_time_q) >= {16'd0, cfg.graph_hold_ms}) begin
						graph_d      = 1'b1;
						redraw_due_d = 1'b1;
					end
				end

				// Pick the highest CO level whose test passes
				if (co_valid_q) begin
					for (int i = 0; i < 3; i++) begin
						th_ext  = signed'({2'b00, th[i]});
						rel_ext = th_ext - signed'({9'd0, cfg.co_release_margin});
						if (co_ext >= th_ext ||
						    (alarm_lvl_q > 2'(i) && co_ext >= rel_ext)) begin
							lvl = 2'(i + 1);
						end
					end
				end
				if (lvl != 2'd0 && alarm_lvl_q == 2'd0) begin
					power_d = PWR_FULL;
				end
				if (lvl == 2'd0 && alarm_lvl_q != 2'd0) begin
					last_act_d = item.now_ms;
				end
				alarm_lvl_d = lvl;

				// Battery alarm with latch hysteresis
				bat_limit = bat_latched_q ? cfg.battery_release_mv : cfg.battery_low_mv;
				bat_low   = (battery_q >= cfg.battery_sense_min_mv) && (battery_q < bat_limit);
				if (!bat_low) begin
					bat_acked_d = 1'b0;
				end
				if (bat_low && !bat_latched_q && lvl == 2'd0) begin
					power_d = PWR_FULL;
				end
				bat_latched_d = bat_low;
				takeover      = bat_low && !bat_acked_d && lvl == 2'd0;

				// Blink during alarm, otherwise inactivity power-down
				if (lvl != 2'd0) begin
					blink_d = phase;
				end else begin
					blink_d = 1'b0;
					if (takeover) begin
						power_d = PWR_FULL;
					end else begin
						idle = item.now_ms - last_act_d;
						if (idle > OFF_AFTER_MS) begin
							power_d = PWR_OFF;
						end else if (idle > DIM_AFTER_MS) begin
							power_d = PWR_DIM;
						end else begin
							power_d = PWR_FULL;
						end
					end
				end

				// Throttled redraw
				if (!(power_d == PWR_OFF && lvl == 2'd0) &&
				    (redraw_due_d || (item.now_ms - last_redraw_q) >= REDRAW_MS)) begin
					last_redraw_d = item.now_ms;
					redraw_due_d  = 1'b0;
					if (lvl != 2'd0) begin
						screen_d = SCR_CO_ALARM;
					end else if (takeover) begin
						screen_d = SCR_BATTERY;
					end else if (graph_d) begin
						screen_d = SCR_GRAPH;
					end else begin
						screen_d = SCR_VALUE;
					end
				end
			end
			CMD_PRESS: begin
				held_d       = 1'b1;
				press_time_d = item.now_ms;
				rotate_d     = power_q == PWR_FULL && alarm_lvl_q == 2'd0 &&
				               !(bat_latched_q && !bat_acked_q);
				if (alarm_lvl_q == 2'd0 && bat_latched_q && !bat_acked_q) begin
					bat_acked_d = 1'b1;
				end
				last_act_d   = item.now_ms;
				power_d      = PWR_FULL;
				redraw_due_d = 1'b1;
			end
			CMD_RELEASE: begin
				held_d = 1'b0;
				if (graph_q) begin
					graph_d = 1'b0;
				end else if (rotate_q &&
				             (item.now_ms - press_time_q) < {16'd0, cfg.graph_hold_ms}) begin
					if (tab_sel_q == TAB_W'(NUM_TABS - 1)) begin
						tab_sel_d = '0;
					end else begin
						tab_sel_d = tab_sel_q + 1'b1;
					end
				end
				last_act_d   = item.now_ms;
				power_d      = PWR_FULL;
				redraw_due_d = 1'b1;
			end
			CMD_SAMPLE: begin
				co_value_d = item.co_reading;
				co_valid_d = item.co_present;
				battery_d  = item.battery_mv;
			end
			default: begin
				screen_d = SCR_NONE;
			end
		endcase
	end

	// Result word from the updated state
	assign tab_wide                = {2'b00, tab_sel_d};
	assign result.power_mode       = power_d;
	assign result.alarm_level      = alarm_lvl_d;
	assign result.invert_on        = blink_d;
	assign result.screen           = screen_d;
	assign result.tab_index        = tab_wide[1:0];
	assign result.battery_reminder = bat_latched_d && bat_acked_d;

	// Commit state on each processed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_sel_q     <= TAB_W'(NUM_TABS - 1);
			alarm_lvl_q   <= '0;
			bat_latched_q <= 1'b0;
			bat_acked_q   <= 1'b0;
			power_q       <= PWR_FULL;
			last_act_q    <= '0;
			last_redraw_q <= '0;
			blink_q       <= 1'b0;
			held_q        <= 1'b0;
			rotate_q      <= 1'b0;
			graph_q       <= 1'b0;
			press_time_q  <= '0;
			co_value_q    <= '0;
			co_valid_q    <= 1'b0;
			battery_q     <= '0;
			redraw_due_q  <= 1'b1;
		end else if (fire) begin
			tab_sel_q     <= tab_sel_d;
			alarm_lvl_q   <= alarm_lvl_d;
			bat_latched_q <= bat_latched_d;
			bat_acked_q   <= bat_acked_d;
			power_q       <= power_d;
			last_act_q    <= last_act_d;
			last_redraw_q <= last_redraw_d;
			blink_q       <= blink_d;
			held_q        <= held_d;
			rotate_q      <= rotate_d;
			graph_q       <= graph_d;
			press_time_q  <= press_time_d;
			co_value_q    <= co_value_d;
			co_valid_q    <= co_valid_d;
			battery_q     <= battery_d;
			redraw_due_q  <= redraw_due_d;
		end
	end

endmodule

>>> src/alarm_display_mode_controller.sv
// An accepted item word is registered at the input, and its result word in the result register.
// Throughput: one item per cycle while result_stall is low; item_stall rises only
// while a result word waits under result_stall. The blink-phase multiply and the
// state update share the one stage between the input and result registers.
// Reset (arst_n low): settings return to their defaults, state to the power-up
// values (last tab selected, no alarms, panel bright, redraw due), pipeline empty.
module alarm_display_mode_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  adm_pkg::in_word_t   item,
	output logic                result_valid,
	input  logic                result_stall,
	output adm_pkg::out_word_t  result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import adm_pkg::*;

	cfg_t      cfg_q;
	logic      valid_s1;
	in_word_t  item_s1;
	logic      phase;
	logic      advance;
	out_word_t core_result;
	out_word_t result_q;
	logic      result_valid_q;

	// Whole pipeline moves when the result register is free or drains
	assign advance      = !result_valid_q || !result_stall;
	assign item_stall   = !advance;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Register file writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.co_level_one         <= CO_LEVEL_ONE_RST;
			cfg_q.co_level_two         <= CO_LEVEL_TWO_RST;
			cfg_q.co_level_three       <= CO_LEVEL_THREE_RST;
			cfg_q.co_release_margin    <= CO_MARGIN_RST;
			cfg_q.battery_low_mv       <= BAT_LOW_RST;
			cfg_q.battery_release_mv   <= BAT_RELEASE_RST;
			cfg_q.battery_sense_min_mv <= BAT_SENSE_MIN_RST;
			cfg_q.graph_hold_ms        <= LONG_PRESS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_CO_LEVEL_ONE:   cfg_q.co_level_one         <= cfg_data[14:0];
				REG_CO_LEVEL_TWO:   cfg_q.co_level_two         <= cfg_data[14:0];
				REG_CO_LEVEL_THREE: cfg_q.co_level_three       <= cfg_data[14:0];
				REG_CO_MARGIN:      cfg_q.co_release_margin    <= cfg_data[7:0];
				REG_BAT_LOW:        cfg_q.battery_low_mv       <= cfg_data;
				REG_BAT_RELEASE:    cfg_q.battery_release_mv   <= cfg_data;
				REG_BAT_SENSE_MIN:  cfg_q.battery_sense_min_mv <= cfg_data;
				REG_LONG_PRESS:     cfg_q.graph_hold_ms        <= cfg_data;
				default:            cfg_q                      <= cfg_q;
			endcase
		end
	end

	// Blink phase from the stage-one time stamp
	adm_phase u_phase (
		.now_ms (item_s1.now_ms),
		.phase  (phase)
	);

	// Control side of the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1       <= item_valid;
			result_valid_q <= valid_s1;
		end
	end

	// Payload side of the pipeline
	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1 <= item;
			if (valid_s1) begin
				result_q <= core_result;
			end
		end
	end

	// State update and result build
	adm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (valid_s1 && advance),
		.item   (item_s1),
		.phase  (phase),
		.cfg    (cfg_q),
		.result (core_result)
	);

endmodule

>>> tb/sv/alarm_display_mode_checker.sv
`timescale 1ns / 100ps

module alarm_display_mode_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_stall,
	input  adm_pkg::in_word_t  item,
	input  logic               result_valid,
	input  logic               result_stall,
	input  adm_pkg::out_word_t result,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output int                 outstanding,
	output int                 fail_count
);
	import adm_pkg::*;

	// Panel timing in milliseconds
	localparam logic [31:0] DIM_IDLE_MS  = 32'd30000;
	localparam logic [31:0] OFF_IDLE_MS  = 32'd150000;
	localparam logic [31:0] DRAW_GAP_MS  = 32'd250;
	localparam logic [31:0] BLINK_HALF_MS = 32'd500;

	// Settings as last written
	logic [14:0] co_th [3];
	logic [7:0]  co_margin;
	logic [15:0] bat_low, bat_rel, bat_min, press_len;

	// Display state
	int unsigned        tab_pos;
	logic [1:0]         co_level;
	logic               bat_hold, bat_ack;
	power_t             panel;
	logic [31:0]        active_ms, drawn_ms, pressed_ms;
	logic               inverted, held, can_rotate, graph_on, draw_pending;
	logic signed [15:0] co_sample;
	logic               co_ok;
	logic [15:0]        bat_sample;

	out_word_t due_displays [$];
	int        mismatch_total = 0;

	assign fail_count = mismatch_total;

	task automatic report_mismatch(input string msg);
		$display("%0t: display mismatch: %s", $time, msg);
		mismatch_total++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	task automatic clear_state();
		co_th[0] = 15'd100;
		co_th[1] = 15'd300;
		co_th[2] = 15'd700;
		co_margin = 8'd5;
		bat_low = 16'd6500;
		bat_rel = 16'd6800;
		bat_min = 16'd4500;
		press_len = 16'd400;
		tab_pos = NUM_TABS - 1;
		co_level = 2'd0;
		bat_hold = 1'b0;
		bat_ack = 1'b0;
		panel = PWR_FULL;
		active_ms = '0;
		drawn_ms = '0;
		pressed_ms = '0;
		inverted = 1'b0;
		held = 1'b0;
		can_rotate = 1'b0;
		graph_on = 1'b0;
		draw_pending = 1'b1;
		co_sample = '0;
		co_ok = 1'b0;
		bat_sample = '0;
	endtask

	task automatic apply_setting(input logic [2:0] idx, input logic [15:0] val);
		case (reg_index_t'(idx))
			REG_CO_LEVEL_ONE:   co_th[0] = val[14:0];
			REG_CO_LEVEL_TWO:   co_th[1] = val[14:0];
			REG_CO_LEVEL_THREE: co_th[2] = val[14:0];
			REG_CO_MARGIN:      co_margin = val[7:0];
			REG_BAT_LOW:        bat_low = val;
			REG_BAT_RELEASE:    bat_rel = val;
			REG_BAT_SENSE_MIN:  bat_min = val;
			REG_LONG_PRESS:     press_len = val;
			default: ;
		endcase
	endtask

	// Advance alarms, power and throttle on a tick; pick the screen to draw
	task automatic run_tick(input logic [31:0] now, output screen_t scr);
		int          lvl;
		int          th;
		int          i;
		logic        low_bat, takeover;
		logic [31:0] idle;
		scr = SCR_NONE;
		lvl = 0;
		if (held) begin
			active_ms = now;
			if (can_rotate && !graph_on && (now - pressed_ms) >= {16'd0, press_len}) begin
				graph_on = 1'b1;
				draw_pending = 1'b1;
			end
		end

		// Highest passing level wins; release threshold may go negative
		if (co_ok)
			for (i = 0; i < 3; i++) begin
				th = int'(co_th[i]);
				if (int'(co_sample) >= th ||
						(int'(co_level) > i && int'(co_sample) >= th - int'(co_margin)))
					lvl = i + 1;
			end
		if (lvl > 0 && co_level == 2'd0)
			panel = PWR_FULL;
		if (lvl == 0 && co_level != 2'd0) begin
			inverted = 1'b0;
			active_ms = now;
		end
		co_level = lvl[1:0];

		// Battery alarm latches and releases with hysteresis
		low_bat = (bat_sample >= bat_min) && (bat_sample < (bat_hold ? bat_rel : bat_low));
		if (!low_bat)
			bat_ack = 1'b0;
		if (low_bat && !bat_hold && co_level == 2'd0)
			panel = PWR_FULL;
		bat_hold = low_bat;
		takeover = bat_hold && !bat_ack && co_level == 2'd0;

		if (co_level != 2'd0) begin
			inverted = ((now / BLINK_HALF_MS) & 32'd1) != 32'd0;
		end else begin
			inverted = 1'b0;
			if (takeover) begin
				panel = PWR_FULL;
			end else begin
				idle = now - active_ms;
				if (idle > OFF_IDLE_MS)
					panel = PWR_OFF;
				else if (idle > DIM_IDLE_MS)
					panel = PWR_DIM;
				else
					panel = PWR_FULL;
			end
		end

		// Drop the draw when dark or throttled
		if (panel == PWR_OFF && co_level == 2'd0)
			return;
		if (!draw_pending && (now - drawn_ms) < DRAW_GAP_MS)
			return;
		drawn_ms = now;
		draw_pending = 1'b0;
		if (co_level != 2'd0)
			scr = SCR_CO_ALARM;
		else if (takeover)
			scr = SCR_BATTERY;
		else if (graph_on)
			scr = SCR_GRAPH;
		else
			scr = SCR_VALUE;
	endtask

	task automatic predict_display(input in_word_t w, output out_word_t r);
		screen_t scr;
		scr = SCR_NONE;
		case (cmd_t'(w.cmd))
			CMD_TICK: begin
				run_tick(w.now_ms, scr);
			end
			CMD_SAMPLE: begin
				co_sample = w.co_reading;
				co_ok = w.co_present;
				bat_sample = w.battery_mv;
			end
			CMD_PRESS: begin
				held = 1'b1;
				pressed_ms = w.now_ms;
				can_rotate = panel == PWR_FULL && co_level == 2'd0 && !(bat_hold && !bat_ack);
				if (co_level == 2'd0 && bat_hold && !bat_ack)
					bat_ack = 1'b1;
			end
			CMD_RELEASE: begin
				held = 1'b0;
				if (graph_on)
					graph_on = 1'b0;
				else if (can_rotate && (w.now_ms - pressed_ms) < {16'd0, press_len})
					tab_pos = (tab_pos + 1) % NUM_TABS;
			end
			default: ;
		endcase

		// Any button activity wakes the panel and forces a redraw
		if (w.cmd == CMD_PRESS || w.cmd == CMD_RELEASE) begin
			active_ms = w.now_ms;
			panel = PWR_FULL;
			draw_pending = 1'b1;
		end

		r.power_mode = panel;
		r.alarm_level = co_level;
		r.invert_on = inverted;
		r.screen = scr;
		r.tab_index = tab_pos[1:0];
		r.battery_reminder = bat_hold && bat_ack;
	endtask

	// Watch settings, items and results at each edge
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			clear_state();
			due_displays.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_setting(cfg_index, cfg_data);
			if (item_valid && !item_stall) begin
				predict_display(item, want);
				due_displays.push_back(want);
			end
			if (result_valid && !result_stall) begin
				if (due_displays.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					want = due_displays.pop_front();
					check_field("power_mode", 32'(result.power_mode),
						32'(want.power_mode));
					check_field("alarm_level", 32'(result.alarm_level),
						32'(want.alarm_level));
					check_field("invert_on", 32'(result.invert_on), 32'(want.invert_on));
					check_field("screen", 32'(result.screen), 32'(want.screen));
					check_field("tab_index", 32'(result.tab_index), 32'(want.tab_index));
					check_field("battery_reminder", 32'(result.battery_reminder),
						32'(want.battery_reminder));
				end
			end
			outstanding <= due_displays.size();
		end
	end

endmodule

>>> tb/sv/alarm_display_mode_controller_tb.sv
`timescale 1ns / 100ps

module alarm_display_mode_controller_tb;
	import adm_pkg::*;

	localparam int RUN_LIMIT = 400000;
	localparam int PHASE_WORDS = 125;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	in_word_t    item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	out_word_t   result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	int outstanding;
	int fail_count;
	int cycle_count = 0;
	int words_sent = 0;
	int hold_cnt = 0;
	logic quiet = 1'b0;
	logic backlog_go = 1'b0;
	logic backlog_used = 1'b0;

	// Stimulus-side copy of the settings, used to aim samples at thresholds
	logic [31:0] stamp;
	logic [14:0] th_set [3];
	logic [7:0]  margin_set;
	logic [15:0] low_set, rel_set, min_set, hold_set;

	alarm_display_mode_controller u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	alarm_display_mode_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.outstanding  (outstanding),
		.fail_count   (fail_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hold off the receiver once for a long stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt <= 0;
			backlog_used <= 1'b0;
		end else if (backlog_go && !backlog_used) begin
			hold_cnt <= 150;
			backlog_used <= 1'b1;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// Stall results at random
	always @(posedge clk) begin
		result_stall <= (hold_cnt != 0) || (!quiet && $urandom_range(99) < 18);
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("alarm_display_mode_controller verification failed");
			$finish;
		end
	end

	// Offer one word, with an occasional gap ahead of it
	task automatic push_item(input in_word_t w);
		if (!quiet && $urandom_range(99) < 18) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 18);
		end
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (item_stall);
		words_sent++;
	endtask

	// Tick, press or release; unused fields carry noise
	task automatic send_event(input cmd_t c, input logic [31:0] delta);
		in_word_t w;
		stamp = stamp + delta;
		w.cmd = c;
		w.now_ms = stamp;
		w.co_reading = 16'($urandom());
		w.co_present = 1'($urandom());
		w.battery_mv = 16'($urandom());
		push_item(w);
	endtask

	task automatic send_sample(input logic signed [15:0] co, input logic present,
			input logic [15:0] bat, input logic [31:0] delta);
		in_word_t w;
		stamp = stamp + delta;
		w.cmd = CMD_SAMPLE;
		w.now_ms = stamp;
		w.co_reading = co;
		w.co_present = present;
		w.battery_mv = bat;
		push_item(w);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_settings(input logic [14:0] l1, input logic [14:0] l2,
			input logic [14:0] l3, input logic [7:0] mg, input logic [15:0] blow,
			input logic [15:0] brel, input logic [15:0] bmin, input logic [15:0] lp);
		th_set[0] = l1;
		th_set[1] = l2;
		th_set[2] = l3;
		margin_set = mg;
		low_set = blow;
		rel_set = brel;
		min_set = bmin;
		hold_set = lp;
		write_reg(REG_CO_LEVEL_ONE, {1'b0, l1});
		write_reg(REG_CO_LEVEL_TWO, {1'b0, l2});
		write_reg(REG_CO_LEVEL_THREE, {1'b0, l3});
		write_reg(REG_CO_MARGIN, {8'd0, mg});
		write_reg(REG_BAT_LOW, blow);
		write_reg(REG_BAT_RELEASE, brel);
		write_reg(REG_BAT_SENSE_MIN, bmin);
		write_reg(REG_LONG_PRESS, lp);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering and let every expected word come back
	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (6) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60)
			return $urandom_range(300);
		if (r < 80)
			return $urandom_range(1000, 301);
		if (r < 92)
			return $urandom_range(40000, 1001);
		if (r < 98)
			return $urandom_range(200000, 30000);
		return $urandom();
	endfunction

	// One random scenario: mostly well-formed button and sample sequences
	task automatic random_scenario();
		int          r, n, v, k, b;
		logic [31:0] step;
		in_word_t    w;
		r = $urandom_range(99);
		if (r < 30) begin
			// Sample near a threshold or anywhere, then a few ticks
			k = $urandom_range(2);
			if ($urandom_range(3) != 0) begin
				v = int'(th_set[k]) + int'($urandom_range(margin_set + 6)) -
					int'(margin_set) - 3;
				if (v > 32767)
					v = 32767;
			end else begin
				v = $signed(16'($urandom()));
			end
			if ($urandom_range(3) != 0) begin
				case ($urandom_range(2))
					0: b = int'(low_set);
					1: b = int'(rel_set);
					default: b = int'(min_set);
				endcase
				b = b + int'($urandom_range(80)) - 40;
				if (b < 0)
					b = 0;
				if (b > 65535)
					b = 65535;
			end else begin
				b = $urandom_range(65535);
			end
			send_sample(v[15:0], $urandom_range(99) < 85, b[15:0], $urandom_range(300));
			n = 1 + $urandom_range(2);
			repeat (n) send_event(CMD_TICK, pick_gap());
		end else if (r < 50) begin
			// Short press, maybe a tick in the middle
			send_event(CMD_PRESS, pick_gap());
			if ($urandom_range(1))
				send_event(CMD_TICK, $urandom_range(100));
			send_event(CMD_RELEASE, $urandom_range(hold_set));
			send_event(CMD_TICK, $urandom_range(400));
		end else if (r < 65) begin
			// Long press into the graph, then release
			send_event(CMD_PRESS, pick_gap());
			n = 2 + $urandom_range(2);
			step = hold_set / 2 + $urandom_range(200) + 1;
			repeat (n) send_event(CMD_TICK, step);
			send_event(CMD_RELEASE, $urandom_range(300));
			send_event(CMD_TICK, $urandom_range(300));
		end else if (r < 85) begin
			n = 1 + $urandom_range(3);
			repeat (n) send_event(CMD_TICK, pick_gap());
		end else if (r < 93) begin
			// Long quiet spell into dim or off
			send_event(CMD_TICK, $urandom_range(200000, 30000));
			send_event(CMD_TICK, $urandom_range(300));
		end else begin
			// Noise: any command at any time
			w.cmd = cmd_t'($urandom_range(3));
			w.now_ms = $urandom();
			w.co_reading = 16'($urandom());
			w.co_present = 1'($urandom());
			w.battery_mv = 16'($urandom());
			stamp = w.now_ms;
			push_item(w);
		end
	endtask

	task automatic run_random(input int count);
		int target;
		target = words_sent + count;
		while (words_sent < target)
			random_scenario();
	endtask

	initial begin
		int          i;
		logic [14:0] a, b, c;
		logic [15:0] lo;
		stamp = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default settings, directed walk through the main behaviors
		load_settings(15'd100, 15'd300, 15'd700, 8'd5, 16'd6500, 16'd6800, 16'd4500, 16'd400);
		send_event(CMD_TICK, 0);
		send_event(CMD_TICK, 100);
		send_event(CMD_PRESS, 150);
		send_event(CMD_RELEASE, 100);
		send_event(CMD_PRESS, 300);
		send_event(CMD_PRESS, 10);
		send_event(CMD_TICK, 250);
		send_event(CMD_TICK, 300);
		send_event(CMD_RELEASE, 100);
		send_sample(16'sd700, 1'b1, 16'd9000, 10);
		send_event(CMD_TICK, 10);
		send_event(CMD_TICK, 500);
		send_sample(-16'sd32768, 1'b1, 16'hFFFF, 10);
		send_event(CMD_TICK, 300);
		send_sample(16'sd32767, 1'b0, 16'd6000, 10);
		send_event(CMD_TICK, 300);
		send_event(CMD_PRESS, 10);
		send_event(CMD_RELEASE, 10);
		send_event(CMD_TICK, 300);
		send_sample(16'sd0, 1'b1, 16'd4000, 10);
		send_event(CMD_TICK, 40000);
		send_event(CMD_TICK, 150000);
		send_event(CMD_RELEASE, 10);
		stamp = 32'hFFFF_FF00;
		send_event(CMD_TICK, 0);
		send_event(CMD_TICK, 32'h200);
		run_random(PHASE_WORDS);
		drain();

		// Unordered thresholds, full margin, zero long press
		load_settings(15'd700, 15'd300, 15'd100, 8'd255, 16'd6800, 16'd6500, 16'd0, 16'd0);
		send_sample(16'sd150, 1'b1, 16'd6600, 10);
		send_event(CMD_TICK, 300);
		send_sample(-16'sd100, 1'b1, 16'd0, 10);
		send_event(CMD_TICK, 300);
		send_event(CMD_PRESS, 10);
		send_event(CMD_RELEASE, 1);
		send_event(CMD_TICK, 300);
		run_random(PHASE_WORDS);
		drain();

		// Top extremes, with the receiver backed up for a while
		load_settings(15'h7FFF, 15'h7FFF, 15'h7FFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF);
		backlog_go <= 1'b1;
		run_random(PHASE_WORDS);
		drain();

		// Bottom extremes, both sides running without gaps
		load_settings(15'd0, 15'd0, 15'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd1);
		quiet <= 1'b1;
		run_random(PHASE_WORDS);
		drain();
		quiet <= 1'b0;

		// Random ordered settings
		for (i = 0; i < 3; i++) begin
			a = 15'($urandom_range(1500));
			b = a + 15'($urandom_range(1500));
			c = b + 15'($urandom_range(3000));
			lo = 16'($urandom_range(8000, 5000));
			load_settings(a, b, c, 8'($urandom_range(255)), lo,
				lo + 16'($urandom_range(600)), 16'($urandom_range(6000)),
				16'($urandom_range(1000, 1)));
			run_random(PHASE_WORDS);
			drain();
		end

		if (fail_count == 0)
			$display("alarm_display_mode_controller verification clean");
		else
			$display("alarm_display_mode_controller verification failed");
		$finish;
	end

endmodule

>>> files.f
src/adm_pkg.sv
src/adm_phase.sv
src/adm_core.sv
src/alarm_display_mode_controller.sv
tb/sv/alarm_display_mode_checker.sv
tb/sv/alarm_display_mode_controller_tb.sv
